// File: sv/mtts_pkg.sv
package mtts_pkg;

	localparam int TICK_W    = 24;
	localparam int COUNT_W   = 32;
	localparam int MASK_W    = 4;
	localparam int SLOT_ID_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [TICK_W-1:0]  TICK_MAX         = 24'hFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 32'hFFFF_FFFF;
	localparam logic [COUNT_W-1:0] DEFAULT_INTERVAL = 32'd1000;

	// power-up enables for the four addressable slots, slot 0 in bit 0
	localparam logic [MASK_W-1:0] ENABLE_RESET = 4'b1011;

	// item kinds (s_tuser)
	localparam logic OP_POLL   = 1'b0;
	localparam logic OP_ENABLE = 1'b1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RELOAD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_END = 3'd4;

	// input payload, lowest bit first: tick_now, slot_number, enable_bit, pad
	typedef struct packed {
		logic [4:0]           pad;
		logic                 enable_bit;
		logic [SLOT_ID_W-1:0] slot_number;
		logic [TICK_W-1:0]    tick_now;
	} in_item_t;

	// result payload, lowest bit first: fired_mask, enabled_mask
	typedef struct packed {
		logic [MASK_W-1:0] enabled_mask;
		logic [MASK_W-1:0] fired_mask;
	} out_item_t;

	localparam int S_TDATA_W = $bits(in_item_t);
	localparam int M_TDATA_W = $bits(out_item_t);

endpackage

// File: sv/multi_task_tick_scheduler.sv
// Periodic task tick scheduler.
//
// Input stream (s_*): one transfer per item. s_tuser[0] is the kind: a poll
// carrying a sample of the 24-bit down-counting system tick, or an enable
// write for one slot. Every accepted item yields exactly one result on the
// output stream (m_*): which slots fired on this poll, and the enable state
// of slots 0..3 after the item.
// Config port: cfg_we/cfg_index/cfg_data, index 0 = tick reload, 1..4 =
// interval of slots 0..3. Write only while the block is idle.
//
// Latency: the result appears on m_* the cycle after the input transfer.
// Throughput: one item per clock. All slots are updated in parallel in the
// accept cycle (24-bit subtract, 25-bit wrap add, 32-bit saturating add and
// compare per slot); the result sits in a single output register.
// Stall: s_tready stays high while the output register is empty or being
// drained, so a new item enters in the same cycle the held result leaves.
// While m_tready is low with a result held, s_tready is low.
// Reset (arst_n low, asynchronous): counts cleared, last ticks 0xFFFFFF,
// slots 0, 1, 3 enabled, intervals 1000, reload 0xFFFFFF, output empty.
module multi_task_tick_scheduler #(
	parameter int SLOT_COUNT = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [mtts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtts_pkg::CFG_W-1:0]         cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mtts_pkg::S_TDATA_W-1:0]     s_tdata,  // tick_now, slot_number, enable_bit, 0s
	input  logic                               s_tuser,  // op
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mtts_pkg::M_TDATA_W-1:0]     m_tdata   // fired_mask, enabled_mask
);
	import mtts_pkg::*;

	// config registers
	logic [TICK_W-1:0]  reload_q;
	logic [COUNT_W-1:0] interval_q [SLOT_COUNT];

	// per-slot state
	logic [COUNT_W-1:0] count_q [SLOT_COUNT];
	logic [TICK_W-1:0]  prev_q  [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] en_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	in_item_t item;
	logic     accept;
	logic     is_poll;

	logic [SLOT_COUNT-1:0] fire;
	logic [SLOT_COUNT-1:0] en_next;
	logic [SLOT_COUNT-1:0] sel;
	logic [COUNT_W-1:0]    count_sat [SLOT_COUNT];

	out_item_t result;

	assign item     = in_item_t'(s_tdata);
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_poll  = (s_tuser == OP_POLL);

	// per-slot datapath, slots are independent
	always_comb begin
		logic              lt;
		logic [TICK_W:0]   wrap;
		logic [TICK_W:0]   delta;
		logic [COUNT_W:0]  sum;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			fire[i] = en_q[i] && (count_q[i] > interval_q[i]);
			lt      = item.tick_now < prev_q[i];
			// down counter wrapped past reload; sample above reload plus the last sample gives 0
			wrap    = {1'b0, reload_q} + {1'b0, prev_q[i]};
			if (lt) begin
				delta = {1'b0, prev_q[i] - item.tick_now};
			end else if (wrap < {1'b0, item.tick_now}) begin
				delta = '0;
			end else begin
				delta = wrap - {1'b0, item.tick_now};
			end
			sum          = {1'b0, count_q[i]} + (COUNT_W+1)'(delta);
			count_sat[i] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
			sel[i]       = !is_poll && (32'(item.slot_number) == i);
			en_next[i]   = sel[i] ? item.enable_bit : en_q[i];
		end
	end

	always_comb begin
		result = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < SLOT_COUNT) begin
				result.fired_mask[i]   = is_poll && fire[i];
				result.enabled_mask[i] = en_next[i];
			end
		end
	end

	// config writes; writes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= TICK_MAX;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				interval_q[i] <= DEFAULT_INTERVAL;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_TICK_RELOAD) begin
				reload_q <= cfg_data[TICK_W-1:0];
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (cfg_index >= REG_INTERVAL_0 && cfg_index <= REG_INTERVAL_END &&
				    32'(cfg_index - REG_INTERVAL_0) == i) begin
					interval_q[i] <= cfg_data;
				end
			end
		end
	end

	// slot state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				count_q[i] <= '0;
				prev_q[i]  <= TICK_MAX;
				en_q[i]    <= (i < MASK_W) ? ENABLE_RESET[i % MASK_W] : 1'b0;
			end
		end else if (accept) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (is_poll) begin
					if (en_q[i]) begin
						count_q[i] <= fire[i] ? '0 : count_sat[i];
						prev_q[i]  <= item.tick_now;
					end
				end else if (sel[i]) begin
					en_q[i] <= item.enable_bit;
					if (!item.enable_bit) begin
						count_q[i] <= '0;
						prev_q[i]  <= TICK_MAX;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// File: sv/mtts_checker.sv
module mtts_checker #(
	parameter int SLOT_COUNT = 4
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [mtts_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mtts_pkg::M_TDATA_W-1:0] m_tdata
);
	import mtts_pkg::*;

	in_item_t  item;
	out_item_t res;
	logic      in_xfer;

	assign item    = in_item_t'(s_tdata);
	assign res     = out_item_t'(m_tdata);
	assign in_xfer = s_tvalid && s_tready;

	// held result must not change under backpressure
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted item shows up as a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_tvalid)
		else $error("no result one cycle after input transfer");

	// only enabled slots can fire
	a_fire_en: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.fired_mask & ~res.enabled_mask) == '0)
		else $error("disabled slot reported as fired");

	// enable write shows in the very next result, with nothing fired
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tuser == OP_ENABLE && 32'(item.slot_number) < SLOT_COUNT |=>
		res.fired_mask == '0 &&
		((res.enabled_mask >> $past(item.slot_number)) & 4'b0001) ==
		{3'b000, $past(item.enable_bit)})
		else $error("enable write not reflected in result");

endmodule

bind multi_task_tick_scheduler mtts_checker #(.SLOT_COUNT(SLOT_COUNT)) u_mtts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mtts_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int N_DIR       = 23;

	// one directed item; known = 1 means the expected result is typed in the row
	typedef struct packed {
		logic              op;
		logic [TICK_W-1:0] tick;
		logic [1:0]        slot;
		logic              en;
		logic              known;
		logic [3:0]        fired;
		logic [3:0]        enabled;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // tick_now, slot_number, enable_bit, 0s
	logic                 s_tuser;   // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // fired_mask, enabled_mask

	// scheduler image: configuration and per-slot timing state
	logic [TICK_W-1:0]  reload_cfg;
	logic [COUNT_W-1:0] interval_cfg [MASK_W];
	logic [COUNT_W-1:0] acc_cnt      [MASK_W];
	logic [TICK_W-1:0]  last_tick    [MASK_W];
	logic [MASK_W-1:0]  slot_on;

	out_item_t pending_results [$];
	int        mismatch_count = 0;
	int        results_seen   = 0;
	int        cycle_count    = 0;
	int        tick_pos       = 0;   // position of the simulated down counter
	bit        quiet          = 0;   // neither side draws new random gaps while set

	// Directed items, run with the reset configuration. Typed results are the
	// ones that follow straight from reset state, the enable masks, and the
	// first fire of the default-interval slots.
	stim_row_t dir_rows [N_DIR] = '{
		'{OP_POLL,   24'hFFFFF0, 2'd0, 1'b0, 1'b1, 4'h0, 4'hB},  // first sample, no fire
		'{OP_ENABLE, 24'h000000, 2'd2, 1'b1, 1'b1, 4'h0, 4'hF},  // slot 2 on
		'{OP_POLL,   24'hFFFFF0, 2'd0, 1'b0, 1'b1, 4'h0, 4'hF},  // same tick: full reload added
		'{OP_POLL,   24'h000000, 2'd0, 1'b0, 1'b1, 4'hB, 4'hF},  // slots 0,1,3 fire
		'{OP_POLL,   24'h000000, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'hFFFFFF, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},  // top tick, wrap term zero
		'{OP_ENABLE, 24'h000000, 2'd0, 1'b0, 1'b1, 4'h0, 4'hE},
		'{OP_ENABLE, 24'h000000, 2'd3, 1'b0, 1'b1, 4'h0, 4'h6},
		'{OP_ENABLE, 24'h000000, 2'd1, 1'b0, 1'b1, 4'h0, 4'h4},
		'{OP_ENABLE, 24'h000000, 2'd2, 1'b0, 1'b1, 4'h0, 4'h0},
		'{OP_POLL,   24'h123456, 2'd0, 1'b0, 1'b1, 4'h0, 4'h0},  // all slots off
		'{OP_ENABLE, 24'h000000, 2'd0, 1'b1, 1'b1, 4'h0, 4'h1},
		'{OP_ENABLE, 24'h000000, 2'd1, 1'b1, 1'b1, 4'h0, 4'h3},
		'{OP_ENABLE, 24'h000000, 2'd2, 1'b1, 1'b1, 4'h0, 4'h7},
		'{OP_ENABLE, 24'h000000, 2'd3, 1'b1, 1'b1, 4'h0, 4'hF},
		'{OP_POLL,   24'h800000, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'h7FFFFF, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'h000001, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_ENABLE, 24'h000000, 2'd3, 1'b1, 1'b1, 4'h0, 4'hF},  // enable while on: no change
		'{OP_POLL,   24'h555555, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'hAAAAAA, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'hFFFFFF, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0},
		'{OP_POLL,   24'h000000, 2'd0, 1'b0, 1'b0, 4'h0, 4'h0}
	};

	multi_task_tick_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// gap length for either side: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// ticks elapsed between two samples of the down counter
	function automatic logic [COUNT_W-1:0] tick_gap(input logic [TICK_W-1:0] prev,
			input logic [TICK_W-1:0] now);
		longint d;
		if (now < prev)
			return COUNT_W'(prev - now);
		d = longint'(reload_cfg) - longint'(now) + longint'(prev);
		// sample above the reload value plus the last tick: wrap term negative, counts as nothing
		if (d < 0)
			return '0;
		return COUNT_W'(d);
	endfunction

	// advance the scheduler image by one item and return the result it gives
	function automatic out_item_t sched_step(input logic op, input logic [TICK_W-1:0] now,
			input logic [1:0] slot, input logic en);
		out_item_t   r;
		logic [32:0] sum;
		r = '0;
		if (op == OP_POLL) begin
			for (int s = 0; s < MASK_W; s++) begin
				if (!slot_on[s])
					continue;
				// fire test uses the count from before this sample
				if (acc_cnt[s] > interval_cfg[s]) begin
					acc_cnt[s] = '0;
					r.fired_mask[s] = 1'b1;
				end else begin
					sum = {1'b0, acc_cnt[s]} + tick_gap(last_tick[s], now);
					acc_cnt[s] = sum[32] ? COUNT_MAX : sum[31:0];
				end
				last_tick[s] = now;
			end
		end else begin
			slot_on[slot] = en;
			// disable also clears the timing; enable leaves it alone
			if (!en) begin
				acc_cnt[slot] = '0;
				last_tick[slot] = TICK_MAX;
			end
		end
		r.enabled_mask = slot_on;
		return r;
	endfunction

	// Offer one item after a random gap and wait for its transfer. Called right
	// after a rising edge; s_tvalid gets at most one assignment per step.
	task automatic send_item(input logic op, input logic [TICK_W-1:0] tick,
			input logic [1:0] slot, input logic en, input logic known,
			input out_item_t typed);
		int        gap;
		out_item_t pred;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= in_item_t'{5'd0, en, slot, tick};
		do
			@(posedge clk);
		while (!s_tready);
		pred = sched_step(op, tick, slot, en);
		pending_results.push_back(known ? typed : pred);
	endtask

	// stop offering and let every outstanding result come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One configuration phase: write all registers while idle, then random items.
	// Most polls follow a down counter stepping by up to max_step (wrapping at
	// the reload value); noise polls carry any 24-bit tick, above reload too.
	task automatic run_phase(input logic [TICK_W-1:0] reload,
			input logic [COUNT_W-1:0] iv0, input logic [COUNT_W-1:0] iv1,
			input logic [COUNT_W-1:0] iv2, input logic [COUNT_W-1:0] iv3,
			input int n_items, input int max_step, input int noise_pct,
			input int enable_pct, input bit enable_only);
		logic [COUNT_W-1:0] iv [MASK_W];
		logic [TICK_W-1:0]  tk;
		logic [1:0]         sl;
		logic               en;
		iv[0] = iv0;
		iv[1] = iv1;
		iv[2] = iv2;
		iv[3] = iv3;
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_TICK_RELOAD;
		cfg_data  <= CFG_W'(reload);
		@(posedge clk);
		reload_cfg = reload;
		for (int s = 0; s < MASK_W; s++) begin
			cfg_index <= REG_INTERVAL_0 + CFG_IDX_W'(s);
			cfg_data  <= iv[s];
			@(posedge clk);
			interval_cfg[s] = iv[s];
		end
		cfg_we <= 1'b0;
		if (tick_pos > int'(reload))
			tick_pos = int'(reload);
		// long-run phase: every slot on, and it stays on
		if (enable_only)
			for (int s = 0; s < MASK_W; s++)
				send_item(OP_ENABLE, TICK_W'($urandom), 2'(s), 1'b1, 1'b0, '0);
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			tk = TICK_W'($urandom);
			sl = 2'($urandom);
			en = 1'($urandom);
			if ($urandom_range(0, 99) < enable_pct) begin
				send_item(OP_ENABLE, tk, sl, enable_only ? 1'b1 : en, 1'b0, '0);
			end else if ($urandom_range(0, 99) < noise_pct) begin
				send_item(OP_POLL, tk, sl, en, 1'b0, '0);
			end else begin
				tick_pos = tick_pos - $urandom_range(0, max_step);
				if (tick_pos < 0)
					tick_pos = tick_pos + int'(reload) + 1;
				if (tick_pos < 0)
					tick_pos = 0;
				send_item(OP_POLL, TICK_W'(tick_pos), sl, en, 1'b0, '0);
			end
		end
		quiet = 0;
	endtask

	// result side: check each transfer, pick the next stall
	initial begin
		int        hold_cycles;
		bit        pressure_done;
		out_item_t got;
		out_item_t want;
		hold_cycles   = 0;
		pressure_done = 0;
		m_tready      = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata);
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with none expected: fired_mask %h enabled_mask %h",
						got.fired_mask, got.enabled_mask);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.fired_mask !== want.fired_mask) begin
						$error("fired_mask: expected %h, got %h",
							want.fired_mask, got.fired_mask);
						mismatch_count++;
					end
					if (got.enabled_mask !== want.enabled_mask) begin
						$error("enabled_mask: expected %h, got %h",
							want.enabled_mask, got.enabled_mask);
						mismatch_count++;
					end
				end
			end
			// one long hold-off so the output register fills and s_tready drops
			if (!pressure_done && results_seen >= 300) begin
				pressure_done = 1;
				hold_cycles   = 150;
			end
			if (hold_cycles == 0 && !quiet && $urandom_range(0, 99) < 25)
				hold_cycles = idle_len();
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multi_task_tick_scheduler test failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_POLL;

		// image of the reset state
		reload_cfg = TICK_MAX;
		slot_on    = ENABLE_RESET;
		for (int s = 0; s < MASK_W; s++) begin
			interval_cfg[s] = DEFAULT_INTERVAL;
			acc_cnt[s]      = '0;
			last_tick[s]    = TICK_MAX;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].op, dir_rows[i].tick, dir_rows[i].slot, dir_rows[i].en,
				dir_rows[i].known, out_item_t'{dir_rows[i].enabled, dir_rows[i].fired});

		// full-range counter, zero and tiny intervals fire often
		run_phase(24'hFFFFFF, 32'd0, 32'd1, 32'd1000, 32'd5000, 170, 300, 8, 8, 0);
		// reload 0: any rising sample gives a negative wrap term
		run_phase(24'h000000, 32'd2, 32'd10, 32'd0, 32'd100, 150, 0, 30, 10, 0);
		// short counter period, near-maximum interval on slot 2
		run_phase(24'd1000, 32'd500, 32'd3000, 32'hFFFFFFFE, 32'd0, 200, 200, 10, 8, 0);
		// held tick adds a full reload per poll: slots 0 and 2 saturate, never fire
		run_phase(24'hFFFFFF, 32'hFFFFFFFF, 32'd7, 32'hFFFFFFFF, 32'd20, 330, 0, 3, 3, 1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("multi_task_tick_scheduler test passed");
		else
			$display("multi_task_tick_scheduler test failed");
		$finish;
	end

endmodule

// File: sim.f
sv/mtts_pkg.sv
sv/multi_task_tick_scheduler.sv
sv/mtts_checker.sv
tb/tb_top.sv
